>>> hdl/alrp_pkg.sv
// ----------------------------------------------------------------------------
// alrp_pkg
// types, codes and reset values shared by the link rate pacer files
// ----------------------------------------------------------------------------
`default_nettype none

package alrp_pkg;

  // time base width range is 16 to 64 bits
  localparam int TimeWidthDef = 32;
  localparam int TimeExtW     = 64;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  // event codes
  typedef enum logic [1:0] {
    FUNC_FRAME = 2'd0,
    FUNC_DROP  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIRED_DECIM = 8'd0,
    REG_DECIM_MAX   = 8'd1,
    REG_DROP_LIMIT  = 8'd2,
    REG_CALM_START  = 8'd3,
    REG_CALM_STEP   = 8'd4,
    REG_CALM_CAP    = 8'd5,
    REG_PROBE_WIN   = 8'd6,
    REG_BINARY_MODE = 8'd7
  } reg_idx_e;

  // register reset values
  localparam logic [7:0]  WiredDecimRst = 8'd3;
  localparam logic [7:0]  DecimMaxRst   = 8'd8;
  localparam logic [7:0]  DropLimitRst  = 8'd2;
  localparam logic [7:0]  CalmStartRst  = 8'd5;
  localparam logic [7:0]  CalmStepRst   = 8'd5;
  localparam logic [7:0]  CalmCapRst    = 8'd30;
  localparam logic [31:0] ProbeWinRst   = 32'd10000;

  localparam logic [7:0] SatMax    = 8'd255;
  localparam logic [7:0] DecimTop  = 8'd128;

  typedef struct packed {
    logic [1:0]  func;
    logic        link_ready;
    logic [31:0] now_ms;
  } evt_t;

  typedef struct packed {
    logic       ble_send;
    logic       wired_send;
    logic [7:0] decim;
    logic [7:0] drops_last_second;
    logic [7:0] calm_need;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    logic [7:0] r;
    r = (v == SatMax) ? SatMax : v + 8'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/alrp_ifs.sv
// ----------------------------------------------------------------------------
// alrp interfaces
// valid/ready channels for events, results and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface alrp_evt_if;
  import alrp_pkg::*;
  logic valid;
  logic ready;
  evt_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface alrp_res_if;
  import alrp_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface alrp_cfg_if;
  import alrp_pkg::*;
  logic valid;
  logic ready;
  cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/alrp_out_buf.sv
// ----------------------------------------------------------------------------
// alrp_out_buf
// two-entry result buffer, decouples the receiver from the event side
// ----------------------------------------------------------------------------
`default_nettype none

module alrp_out_buf
  import alrp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire res_t   push_data_i,
  output logic        full_o,
  alrp_res_if.source  res_o
);

  res_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop           = res_o.valid && res_o.ready;
  assign res_o.valid   = (cnt_q != 2'd0);
  assign res_o.payload = ent_q[rd_ptr_q];
  assign full_o        = (cnt_q == 2'd2);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/aimd_link_rate_pacer_core.sv
// ----------------------------------------------------------------------------
// aimd_link_rate_pacer_core
// drop-driven decimation control for a wireless and a wired frame stream
// ----------------------------------------------------------------------------
// usage:
//  - evt_i carries one event per transfer: frame built, frame dropped or a
//    one-second tick with the uptime in ms
//  - every accepted event yields exactly one result transfer on res_o, in
//    order, with the send gates (frame events only) and the pacer status
//  - cfg_i writes one register per transfer and is always ready; write only
//    while no event is in flight
//  - the result is written into the output buffer and is valid in the cycle after the event transfer
//  - throughput: one event per cycle; the state update is a single pass of
//    compare/increment logic from the event port into the state and the
//    result buffer
//  - a two-entry result buffer sits at the output, so an event is still
//    taken while one result waits; evt_i.ready drops only while both
//    entries are held by a stalled receiver
//  - reset clears counters, sets the decimation to 1 and loads the
//    registers with their defaults; results in the buffer are discarded
// ----------------------------------------------------------------------------
`default_nettype none

module aimd_link_rate_pacer_core
  import alrp_pkg::*;
#(
  parameter int TIME_WIDTH = TimeWidthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  alrp_evt_if.sink   evt_i,
  alrp_cfg_if.sink   cfg_i,
  alrp_res_if.source res_o
);

  // configuration registers
  logic [7:0]  wired_decim_q, wired_decim_d;
  logic [7:0]  decim_max_q, decim_max_d;
  logic [7:0]  drop_limit_q, drop_limit_d;
  logic [7:0]  calm_step_q, calm_step_d;
  logic [7:0]  calm_cap_q, calm_cap_d;
  logic [31:0] probe_win_q, probe_win_d;
  logic        binary_mode_q, binary_mode_d;

  // pacer state
  logic [7:0]            frame_skip_q, frame_skip_d;
  logic [7:0]            wired_skip_q, wired_skip_d;
  logic [7:0]            decim_q, decim_d;
  logic [7:0]            calm_cnt_q, calm_cnt_d;
  logic [7:0]            calm_need_q, calm_need_d;
  logic [TIME_WIDTH-1:0] last_probe_q, last_probe_d;
  logic [7:0]            drop_cnt_q, drop_cnt_d;
  logic [7:0]            drops_rpt_q, drops_rpt_d;

  logic                  evt_fire;
  logic                  cfg_fire;
  logic                  buf_full;
  logic [TimeExtW-1:0]   now_ext;
  logic [TimeExtW-1:0]   win_ext;
  logic [TIME_WIDTH-1:0] now_w;
  logic [TIME_WIDTH-1:0] win_w;
  logic [TIME_WIDTH-1:0] since;
  logic [8:0]            need_sum;
  logic [7:0]            wired_inc;
  logic [7:0]            frame_inc;
  logic [7:0]            calm_inc;
  logic                  ble_send;
  logic                  wired_send;
  res_t                  res;

  assign evt_fire    = evt_i.valid && evt_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign evt_i.ready = !buf_full;
  assign cfg_i.ready = 1'b1;

  // time values reduced to the time base width
  assign now_ext = {{(TimeExtW-32){1'b0}}, evt_i.payload.now_ms};
  assign win_ext = {{(TimeExtW-32){1'b0}}, probe_win_q};
  assign now_w   = now_ext[TIME_WIDTH-1:0];
  assign win_w   = win_ext[TIME_WIDTH-1:0];
  assign since   = now_w - last_probe_q;

  assign wired_inc = sat_inc(wired_skip_q);
  assign frame_inc = sat_inc(frame_skip_q);
  assign calm_inc  = sat_inc(calm_cnt_q);
  assign need_sum  = {1'b0, calm_need_q} + {1'b0, calm_step_q};

  always_comb begin
    wired_decim_d = wired_decim_q;
    decim_max_d   = decim_max_q;
    drop_limit_d  = drop_limit_q;
    calm_step_d   = calm_step_q;
    calm_cap_d    = calm_cap_q;
    probe_win_d   = probe_win_q;
    binary_mode_d = binary_mode_q;
    frame_skip_d  = frame_skip_q;
    wired_skip_d  = wired_skip_q;
    decim_d       = decim_q;
    calm_cnt_d    = calm_cnt_q;
    calm_need_d   = calm_need_q;
    last_probe_d  = last_probe_q;
    drop_cnt_d    = drop_cnt_q;
    drops_rpt_d   = drops_rpt_q;
    ble_send      = 1'b0;
    wired_send    = 1'b0;

    if (cfg_fire) begin
      case (cfg_i.payload.index)
        REG_WIRED_DECIM: wired_decim_d = cfg_i.payload.data[7:0];
        REG_DECIM_MAX:   decim_max_d  = cfg_i.payload.data[7:0];
        REG_DROP_LIMIT:  drop_limit_d = cfg_i.payload.data[7:0];
        REG_CALM_START: begin
          // new calm need takes effect at once and restarts the calm run
          calm_need_d = cfg_i.payload.data[7:0];
          calm_cnt_d  = 8'd0;
        end
        REG_CALM_STEP:   calm_step_d   = cfg_i.payload.data[7:0];
        REG_CALM_CAP:    calm_cap_d    = cfg_i.payload.data[7:0];
        REG_PROBE_WIN:   probe_win_d   = cfg_i.payload.data;
        REG_BINARY_MODE: binary_mode_d = cfg_i.payload.data[0];
        default: ;
      endcase
    end else if (evt_fire) begin
      case (evt_i.payload.func)
        FUNC_FRAME: begin
          // wired stream: fixed decimation
          if (wired_inc >= wired_decim_q) begin
            wired_skip_d = 8'd0;
            wired_send   = 1'b1;
          end else begin
            wired_skip_d = wired_inc;
          end
          // wireless stream: adaptive decimation, only when the link can take it and binary mode is on
          if (evt_i.payload.link_ready && binary_mode_q) begin
            if (frame_inc >= decim_q) begin
              frame_skip_d = 8'd0;
              ble_send     = 1'b1;
            end else begin
              frame_skip_d = frame_inc;
            end
          end
        end
        FUNC_DROP: begin
          drop_cnt_d = sat_inc(drop_cnt_q);
        end
        FUNC_TICK: begin
          drops_rpt_d = drop_cnt_q;
          drop_cnt_d  = 8'd0;
          if (drop_cnt_q > drop_limit_q) begin
            // congestion: back off, and punish a probe that failed soon
            if ((decim_q < decim_max_q) && (decim_q < DecimTop)) begin
              if ((since < win_w) && (calm_need_q < calm_cap_q)) begin
                calm_need_d = need_sum[8] ? SatMax : need_sum[7:0];
              end
              decim_d = {decim_q[6:0], 1'b0};
            end
            calm_cnt_d = 8'd0;
          end else if (drop_cnt_q == 8'd0) begin
            // calm second: probe up once enough have passed
            if (decim_q > 8'd1) begin
              if (calm_inc >= calm_need_q) begin
                decim_d      = {1'b0, decim_q[7:1]};
                last_probe_d = now_w;
                calm_cnt_d   = 8'd0;
              end else begin
                calm_cnt_d = calm_inc;
              end
            end
          end else begin
            calm_cnt_d = 8'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.ble_send          = ble_send;
    res.wired_send        = wired_send;
    res.decim             = decim_d;
    res.drops_last_second = drops_rpt_d;
    res.calm_need         = calm_need_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wired_decim_q <= WiredDecimRst;
      decim_max_q   <= DecimMaxRst;
      drop_limit_q  <= DropLimitRst;
      calm_step_q   <= CalmStepRst;
      calm_cap_q    <= CalmCapRst;
      probe_win_q   <= ProbeWinRst;
      binary_mode_q <= 1'b1;
      frame_skip_q  <= 8'd0;
      wired_skip_q  <= 8'd0;
      decim_q       <= 8'd1;
      calm_cnt_q    <= 8'd0;
      calm_need_q   <= CalmStartRst;
      last_probe_q  <= '0;
      drop_cnt_q    <= 8'd0;
      drops_rpt_q   <= 8'd0;
    end else begin
      wired_decim_q <= wired_decim_d;
      decim_max_q   <= decim_max_d;
      drop_limit_q  <= drop_limit_d;
      calm_step_q   <= calm_step_d;
      calm_cap_q    <= calm_cap_d;
      probe_win_q   <= probe_win_d;
      binary_mode_q <= binary_mode_d;
      frame_skip_q  <= frame_skip_d;
      wired_skip_q  <= wired_skip_d;
      decim_q       <= decim_d;
      calm_cnt_q    <= calm_cnt_d;
      calm_need_q   <= calm_need_d;
      last_probe_q  <= last_probe_d;
      drop_cnt_q    <= drop_cnt_d;
      drops_rpt_q   <= drops_rpt_d;
    end
  end

  // result buffer
  alrp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (evt_fire),
    .push_data_i (res),
    .full_o      (buf_full),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // decimation only ever doubles from 1 or halves, so it stays a power of two
  a_decim_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(decim_q))
    else $error("decimation is not a power of two");

  // a tick taken with no register write in the same cycle starts a fresh drop count
  a_tick_clears_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_fire && !cfg_fire && (evt_i.payload.func == FUNC_TICK)) |=> (drop_cnt_q == 8'd0))
    else $error("drop count not cleared by tick");

  // an accepted event always shows up as a pending result
  a_evt_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_fire |=> res_o.valid)
    else $error("accepted event produced no result");

  // the wired gate never fires twice in a row while the decimation is above one
  a_wired_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wired_send && (wired_decim_q > 8'd1)) |=> (wired_skip_q == 8'd0))
    else $error("wired skip counter not restarted after send");
`endif

endmodule

`default_nettype wire

>>> tb/aimd_link_rate_pacer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aimd_link_rate_pacer_core_test
// self-checking testbench for the drop-driven link rate pacer
// ----------------------------------------------------------------------------
// A short table of frame, drop and tick events runs first on the reset
// register values. Six register settings follow, each with a stream of
// simulated seconds: frames and drops in random order closed by a tick that
// carries the uptime. Every result transfer is checked field by field against
// the table or an in-bench model of the pacer. Both ends idle at random, and the result
// side is held off once long enough for the core to stall its event input.
// ----------------------------------------------------------------------------

module aimd_link_rate_pacer_core_test;
  import alrp_pkg::*;

  // event code that the core does not use, and a register index with no register
  localparam logic [1:0] FuncSpare   = 2'd3;
  localparam logic [7:0] RegUnmapped = 8'hFF;

  localparam int NumRows     = 25;
  localparam int NumPhases   = 6;
  localparam int PhaseItems  = 30;
  localparam int LongHold    = 150;
  localparam int DrainCycles = 4;

  // one line of the directed table; want is only used where typed is set
  typedef struct packed {
    logic [1:0]  func;
    logic        link_ready;
    logic [31:0] now_ms;
    logic        typed;
    res_t        want;
  } row_t;

  // status right after reset: decim 1, no drops reported, calm need 5
  localparam res_t QuietRes = '{1'b0, 1'b0, 8'd1, 8'd0, 8'd5};

  // ---------------------------------------------------------------------------
  // clock, reset and channels
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  alrp_evt_if evt_if ();
  alrp_cfg_if cfg_if ();
  alrp_res_if res_if ();

  aimd_link_rate_pacer_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // ---------------------------------------------------------------------------
  // pacer model: register copies and state
  // ---------------------------------------------------------------------------
  logic [7:0]  wired_div, decim_ceiling, drop_thresh;
  logic [7:0]  calm_init, calm_incr, calm_ceiling;
  logic [31:0] probe_span;
  logic        bin_mode;

  logic [7:0]  frame_cnt, wired_cnt, decim_now, calm_run, calm_goal;
  logic [7:0]  drop_cnt, drops_shown;
  logic [31:0] probe_stamp;

  res_t expected_results [$];

  int failures        = 0;
  int results_checked = 0;
  int events_sent     = 0;
  int ble_sends       = 0;
  int wired_sends     = 0;
  int decim_ups       = 0;
  int decim_downs     = 0;

  // idle percentages and the long receiver hold-off request
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          stall_asked  = 0;
  int          stall_taken  = 0;
  int          hold_left    = 0;

  // stimulus bookkeeping for the simulated seconds
  logic [31:0] clock_ms;
  logic        storm_left;

  function automatic logic [7:0] bump(input logic [7:0] v);
    return (v == SatMax) ? SatMax : v + 8'd1;
  endfunction

  function automatic void init_pacer_model();
    wired_div     = WiredDecimRst;
    decim_ceiling = DecimMaxRst;
    drop_thresh   = DropLimitRst;
    calm_init     = CalmStartRst;
    calm_incr     = CalmStepRst;
    calm_ceiling  = CalmCapRst;
    probe_span    = ProbeWinRst;
    bin_mode      = 1'b1;
    frame_cnt     = '0;
    wired_cnt     = '0;
    decim_now     = 8'd1;
    calm_run      = '0;
    calm_goal     = CalmStartRst;
    probe_stamp   = '0;
    drop_cnt      = '0;
    drops_shown   = '0;
  endfunction

  function automatic void apply_reg(input logic [7:0] idx, input logic [31:0] val);
    case (idx)
      REG_WIRED_DECIM: wired_div     = val[7:0];
      REG_DECIM_MAX:   decim_ceiling = val[7:0];
      REG_DROP_LIMIT:  drop_thresh   = val[7:0];
      REG_CALM_START: begin
        // a new start value also restarts the calm count
        calm_init = val[7:0];
        calm_goal = val[7:0];
        calm_run  = '0;
      end
      REG_CALM_STEP:   calm_incr     = val[7:0];
      REG_CALM_CAP:    calm_ceiling  = val[7:0];
      REG_PROBE_WIN:   probe_span    = val;
      REG_BINARY_MODE: bin_mode      = val[0];
      default: ;
    endcase
  endfunction

  // advances the model by one event and returns the status it reports
  function automatic res_t pace_event(input evt_t e);
    res_t        r;
    logic [7:0]  drops;
    logic [8:0]  grown;
    logic [31:0] since;
    r = '0;
    case (e.func)
      FUNC_FRAME: begin
        wired_cnt = bump(wired_cnt);
        if (wired_cnt >= wired_div) begin
          wired_cnt    = '0;
          r.wired_send = 1'b1;
        end
        if (e.link_ready && bin_mode) begin
          frame_cnt = bump(frame_cnt);
          if (frame_cnt >= decim_now) begin
            frame_cnt  = '0;
            r.ble_send = 1'b1;
          end
        end
      end
      FUNC_DROP: drop_cnt = bump(drop_cnt);
      FUNC_TICK: begin
        drops       = drop_cnt;
        drops_shown = drops;
        drop_cnt    = '0;
        if (drops > drop_thresh) begin
          // congested second: back off, doubling only while below the ceiling and below 128
          if (decim_now < decim_ceiling && decim_now < DecimTop) begin
            since = e.now_ms - probe_stamp;
            // backing off soon after a probe makes the next probe wait longer
            if (since < probe_span && calm_goal < calm_ceiling) begin
              grown     = {1'b0, calm_goal} + {1'b0, calm_incr};
              calm_goal = grown[8] ? SatMax : grown[7:0];
            end
            decim_now = {decim_now[6:0], 1'b0};
            decim_ups++;
          end
          calm_run = '0;
        end else if (drops == 8'd0) begin
          if (decim_now > 8'd1) begin
            calm_run = bump(calm_run);
            if (calm_run >= calm_goal) begin
              decim_now   = decim_now >> 1;
              probe_stamp = e.now_ms;
              calm_run    = '0;
              decim_downs++;
            end
          end
        end else begin
          calm_run = '0;
        end
      end
      default: ;
    endcase
    r.decim             = decim_now;
    r.drops_last_second = drops_shown;
    r.calm_need         = calm_goal;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table, run on the reset register values
  // ---------------------------------------------------------------------------
  row_t directed_rows [NumRows] = '{
    // first frame goes wireless at decim 1, wired waits for the third
    '{FUNC_FRAME, 1'b1, 32'd0,          1'b1, '{1'b1, 1'b0, 8'd1, 8'd0, 8'd5}},
    '{FUNC_FRAME, 1'b0, 32'd0,          1'b1, QuietRes},
    '{FUNC_FRAME, 1'b1, 32'd0,          1'b1, '{1'b1, 1'b1, 8'd1, 8'd0, 8'd5}},
    // unused code leaves everything alone
    '{FuncSpare,  1'b1, 32'hFFFF_FFFF,  1'b1, QuietRes},
    // calm tick at decim 1 changes nothing
    '{FUNC_TICK,  1'b0, 32'd0,          1'b1, QuietRes},
    '{FUNC_DROP,  1'b1, 32'd0,          1'b1, QuietRes},
    '{FUNC_DROP,  1'b0, 32'd0,          1'b1, QuietRes},
    '{FUNC_DROP,  1'b1, 32'hFFFF_FFFF,  1'b1, QuietRes},
    // three drops over a limit of two: doubling before any probe is a failed probe
    '{FUNC_TICK,  1'b1, 32'd1000,       1'b0, '0},
    '{FUNC_DROP,  1'b0, 32'd0,          1'b0, '0},
    '{FUNC_DROP,  1'b0, 32'd0,          1'b0, '0},
    '{FUNC_DROP,  1'b0, 32'd0,          1'b0, '0},
    '{FUNC_TICK,  1'b0, 32'd5000,       1'b0, '0},
    // one drop: below the limit, only the calm run is cleared
    '{FUNC_DROP,  1'b1, 32'd0,          1'b0, '0},
    '{FUNC_TICK,  1'b1, 32'd6000,       1'b0, '0},
    '{FUNC_FRAME, 1'b1, 32'd0,          1'b0, '0},
    '{FUNC_FRAME, 1'b1, 32'd0,          1'b0, '0},
    '{FUNC_FRAME, 1'b0, 32'd0,          1'b0, '0},
    '{FUNC_FRAME, 1'b1, 32'd0,          1'b0, '0},
    '{FUNC_FRAME, 1'b1, 32'd0,          1'b0, '0},
    '{FUNC_TICK,  1'b0, 32'hFFFF_FFFF,  1'b0, '0},
    '{FUNC_DROP,  1'b1, 32'd0,          1'b0, '0},
    '{FUNC_DROP,  1'b1, 32'd0,          1'b0, '0},
    '{FUNC_DROP,  1'b1, 32'd0,          1'b0, '0},
    // far from the last probe stamp: doubles without raising the calm need
    '{FUNC_TICK,  1'b1, 32'hFFFF_FFF0,  1'b0, '0}
  };

  // register settings per phase, in index order; the last phase is random
  // order: wired decimation, decim_max, drop_limit, calm_start, calm_step,
  //        calm_cap, probe_window_ms, binary_mode
  logic [31:0] phase_regs [NumPhases-1][8] = '{
    '{32'd2,   32'd16,  32'd1,   32'd2,   32'd3,   32'd10,  32'd3000,      32'd1},
    // upper extremes: every drop doubles, calm need saturates
    '{32'd255, 32'd128, 32'd0,   32'd1,   32'd255, 32'd255, 32'hFFFF_FFFF, 32'd1},
    // lower extremes: wired sends every frame, no doubling, text mode
    '{32'd0,   32'd0,   32'd0,   32'd0,   32'd0,   32'd0,   32'd0,         32'd0},
    // saturated drop count just clears a limit of 254, ceiling above 128
    '{32'd1,   32'd200, 32'd254, 32'd255, 32'd1,   32'd254, 32'd2000,      32'd1},
    // saturated drop count never clears a limit of 255
    '{32'd7,   32'd4,   32'd255, 32'd3,   32'd2,   32'd6,   32'd5000,      32'hFFFF_FFFF}
  };

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_event(input evt_t e, input logic typed, input res_t typed_res);
    res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      // idle cycle with junk on the payload
      evt_if.valid   <= 1'b0;
      evt_if.payload <= '{func: 2'($urandom()), link_ready: 1'($urandom()),
                          now_ms: $urandom()};
      @(negedge clk);
    end
    evt_if.valid   <= 1'b1;
    evt_if.payload <= e;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    predicted = pace_event(e);
    expected_results.push_back(typed ? typed_res : predicted);
    if (predicted.ble_send) ble_sends++;
    if (predicted.wired_send) wired_sends++;
    if (e.func != FuncSpare) events_sent++;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // drop valid right after the last transfer, then wait out every result
  task automatic finish_phase();
    @(negedge clk);
    evt_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one simulated second: frames and drops in random order, then the tick
  task automatic run_second();
    int          frames;
    int          drops;
    int          pick;
    logic [31:0] tick_now;
    frames = $urandom_range(3);
    pick   = $urandom_range(99);
    // with a high limit the one storm comes in the first second of the phase
    if (drop_thresh >= 8'd32 && storm_left) pick = 60;
    if (pick < 55) begin
      drops = 0;
    end else if (pick < 80) begin
      // congested second; with a high limit only one storm per phase
      if (drop_thresh < 8'd32) begin
        drops = drop_thresh + 1 + $urandom_range(2);
      end else if (storm_left) begin
        drops      = drop_thresh + 1 + $urandom_range(3);
        storm_left = 1'b0;
      end else begin
        drops = $urandom_range(1, 3);
      end
    end else begin
      // some drops, but not over the limit
      drops = (drop_thresh == 8'd0) ? 0 :
              $urandom_range(1, (drop_thresh < 8'd4) ? drop_thresh : 4);
    end
    while (frames + drops > 0) begin
      if (frames > 0 && (drops == 0 || $urandom_range(1) == 1)) begin
        send_event('{func: FUNC_FRAME, link_ready: ($urandom_range(9) != 0),
                     now_ms: $urandom()}, 1'b0, '0);
        frames--;
      end else begin
        send_event('{func: FUNC_DROP, link_ready: 1'($urandom()), now_ms: $urandom()},
                   1'b0, '0);
        drops--;
      end
    end
    // occasional stray event code
    if ($urandom_range(49) == 0) begin
      send_event('{func: FuncSpare, link_ready: 1'($urandom()), now_ms: $urandom()},
                 1'b0, '0);
    end
    clock_ms = clock_ms + $urandom_range(980, 1020);
    // now and then a tick with a stamp out of nowhere, backwards jumps included
    tick_now = ($urandom_range(29) == 0) ? $urandom() : clock_ms;
    send_event('{func: FUNC_TICK, link_ready: 1'($urandom()), now_ms: tick_now},
               1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random ready, with a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_asked != stall_taken) begin
      stall_taken = stall_asked;
      hold_left   = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no event outstanding");
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("ble_send", {7'd0, want.ble_send}, {7'd0, res_if.payload.ble_send});
        check_field("wired_send", {7'd0, want.wired_send},
                    {7'd0, res_if.payload.wired_send});
        check_field("decim", want.decim, res_if.payload.decim);
        check_field("drops_last_second", want.drops_last_second,
                    res_if.payload.drops_last_second);
        check_field("calm_need", want.calm_need, res_if.payload.calm_need);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [31:0] val;
    logic [31:0] garbage;
    int          phase_start;
    rst_n          = 1'b0;
    evt_if.valid   = 1'b0;
    evt_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    res_if.ready   = 1'b0;
    clock_ms       = '0;
    storm_left     = 1'b0;
    init_pacer_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table on reset values
    src_idle_pct = 30;
    snk_idle_pct = 59;
    for (int i = 0; i < NumRows; i++) begin
      send_event('{func: directed_rows[i].func, link_ready: directed_rows[i].link_ready,
                   now_ms: directed_rows[i].now_ms},
                 directed_rows[i].typed, directed_rows[i].want);
    end
    finish_phase();

    // random seconds under each register setting
    for (int p = 0; p < NumPhases; p++) begin
      case (p / 2)
        0: begin
          src_idle_pct = 30;
          snk_idle_pct = 59;
        end
        1: begin
          src_idle_pct = 59;
          snk_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase

      for (int r = REG_WIRED_DECIM; r <= REG_BINARY_MODE; r++) begin
        if (p < NumPhases - 1) begin
          val = phase_regs[p][r];
        end else begin
          // random setting with junk above each register's width
          garbage = $urandom() & 32'hFFFF_FF00;
          case (r)
            REG_WIRED_DECIM: val = garbage | $urandom_range(1, 8);
            REG_DECIM_MAX:   val = garbage | (32'd1 << $urandom_range(7));
            REG_DROP_LIMIT:  val = garbage | $urandom_range(4);
            REG_CALM_START:  val = garbage | $urandom_range(1, 6);
            REG_CALM_STEP:   val = garbage | $urandom_range(8);
            REG_CALM_CAP:    val = garbage | $urandom_range(1, 40);
            REG_PROBE_WIN:   val = $urandom_range(20000);
            default:         val = $urandom();
          endcase
        end
        write_reg(8'(r), val);
      end
      if (p == NumPhases - 1) write_reg(RegUnmapped, $urandom());

      // hold the result side off while events keep coming, so the buffer
      // fills and the event input stalls
      if (p == NumPhases - 2) stall_asked++;

      clock_ms    = $urandom();
      storm_left  = 1'b1;
      phase_start = events_sent;
      while (events_sent - phase_start < PhaseItems) run_second();
      finish_phase();
    end

    $display("covered %0d events (directed table and %0d register settings), %0d results checked",
             events_sent, NumPhases, results_checked);
    $display("decimation doubled %0d and halved %0d times; %0d wireless and %0d wired sends",
             decim_ups, decim_downs, ble_sends, wired_sends);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $error("timeout with %0d results outstanding", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
